FILE: src/particle_motion_update_assert.svh
// ---------------------------------------------------------------------------
// Particle motion update assertion macros
// Concurrent property shorthands on clk with synchronous reset rst.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_MOTION_UPDATE_ASSERT_SVH
`define PARTICLE_MOTION_UPDATE_ASSERT_SVH

// same-cycle implication
`define PMU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pmu_pkg.sv
// ---------------------------------------------------------------------------
// Particle motion update package
// Request and update payload types, register map and fixed-point helpers.
// ---------------------------------------------------------------------------
package pmu_pkg;

  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int TIME_STEP_W = 17;
  localparam int SIN_W       = 17;

  // word address of the time step register
  localparam logic [ADDR_W-3:0] REG_TIME_STEP = 1'b0;

  localparam logic [TIME_STEP_W-1:0] TIME_STEP_RESET = 17'd1092;

  // heading reduction: 45 * 92, keeps the upper heading bits positive
  localparam logic [13:0] HEAD_OFS    = 14'd4140;
  localparam logic [14:0] MOD45_RCP   = 15'd23302;
  localparam int          MOD45_SHIFT = 20;

  localparam logic [63:0] PI_Q30 = 64'h3243F6A8885A308D >> 30;

  typedef struct packed {
    logic signed [31:0] life_left;
    logic signed [31:0] scale_now;
    logic signed [31:0] scale_target;
    logic [31:0]        color_now;
    logic [31:0]        color_target;
    logic signed [31:0] spin_angle;
    logic signed [31:0] spin_rate;
    logic signed [31:0] speed_now;
    logic signed [31:0] friction_rate;
    logic signed [31:0] heading;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } pmu_req_t;

  typedef struct packed {
    logic               alive;
    logic signed [31:0] life_out;
    logic signed [31:0] scale_out;
    logic [31:0]        color_out;
    logic signed [31:0] angle_out;
    logic [30:0]        speed_out;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
  } pmu_upd_t;

  function automatic logic signed [31:0] sat_q32(input logic signed [63:0] v);
    priority if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

FILE: src/particle_motion_update.sv
// ---------------------------------------------------------------------------
// Particle motion update
// Advances one particle by one frame time step: life, scale, color, spin,
// speed with friction and position along the heading.
// ---------------------------------------------------------------------------
// Nine register stages, one request per cycle while the stages are not
// blocked. Every stage holds when the one after it is full and blocked, so a
// waiting update stalls only the stages behind it and empty stages still
// fill. Heading is reduced to a table index by two reciprocal multiplies;
// the quarter-wave sine table (SINE_TABLE_DEPTH+1 entries, built at
// elaboration) is read once for sine and once for cosine in the same cycle.
// Velocity and step are two chained multiplies in their own stages. The
// time step register sits on an APB port at byte address 0 and may only be
// written while the pipeline is empty.
`include "particle_motion_update_assert.svh"

module particle_motion_update #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pmu_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  pmu_pkg::pmu_req_t         req_data,
  output logic                      upd_valid,
  input  logic                      upd_ready,
  output pmu_pkg::pmu_upd_t         upd_data
);
  import pmu_pkg::*;

  localparam int DEPTH_W   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IDX_W     = $clog2(SINE_TABLE_DEPTH);
  localparam int FOLD_W    = $clog2(5 * SINE_TABLE_DEPTH);
  localparam int W_W       = $clog2(45 * SINE_TABLE_DEPTH);
  localparam int RCP_SHIFT = W_W + 6;
  localparam int RCP_W     = RCP_SHIFT - 5;
  localparam int PROD_W    = 25 + DEPTH_W;
  localparam int IPROD_W   = W_W + RCP_W;

  localparam logic [RCP_W-1:0]   RCP     = RCP_W'(((64'd1 << RCP_SHIFT) + 64'd44) / 64'd45);
  localparam logic [DEPTH_W-1:0] DEPTH_V = DEPTH_W'(SINE_TABLE_DEPTH);
  localparam logic [FOLD_W-1:0]  Q1      = FOLD_W'(SINE_TABLE_DEPTH);
  localparam logic [FOLD_W-1:0]  Q2      = FOLD_W'(2 * SINE_TABLE_DEPTH);
  localparam logic [FOLD_W-1:0]  Q3      = FOLD_W'(3 * SINE_TABLE_DEPTH);
  localparam logic [FOLD_W-1:0]  Q4      = FOLD_W'(4 * SINE_TABLE_DEPTH);

  typedef logic [SIN_W-1:0] sine_rom_t [SINE_TABLE_DEPTH+1];

  // quarter-wave sine magnitude, Q1.16, Taylor series in Q30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    for (int r = 0; r <= SINE_TABLE_DEPTH; r++) begin
      x    = (PI_Q30 * 64'(r)) / 64'(2 * SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      sum  = $signed(x);
      term = x;
      for (int n = 1; n < 20; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      q = (sum + 64'sd8192) >>> 14;
      if (q < 0) begin
        q = 0;
      end
      if (q > 65536) begin
        q = 65536;
      end
      rom[r] = SIN_W'(q);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // returns {negate, quarter-wave offset}
  function automatic logic [DEPTH_W:0] fold(input logic [FOLD_W-1:0] m);
    logic [FOLD_W-1:0] r;
    logic              neg;
    priority if (m < Q1) begin
      r   = m;
      neg = 1'b0;
    end else if (m < Q2) begin
      r   = Q2 - m;
      neg = 1'b0;
    end else if (m < Q3) begin
      r   = m - Q2;
      neg = 1'b1;
    end else begin
      r   = Q4 - m;
      neg = 1'b1;
    end
    return {neg, DEPTH_W'(r)};
  endfunction

  function automatic logic [7:0] clamp_u8(input logic signed [25:0] v);
    priority if (v < 0) begin
      return 8'd0;
    end else if (v > 26'sd255) begin
      return 8'd255;
    end else begin
      return v[7:0];
    end
  endfunction

  // configuration
  logic [TIME_STEP_W-1:0] time_step;
  logic signed [17:0]     dt_s;

  assign pready = 1'b1;
  assign dt_s   = $signed({1'b0, time_step});

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RESET;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_TIME_STEP) begin
      time_step <= pwdata[TIME_STEP_W-1:0];
    end
  end

  always_comb begin
    if (paddr[ADDR_W-1:2] == REG_TIME_STEP) begin
      prdata = {15'd0, time_step};
    end else begin
      prdata = '0;
    end
  end

  // pipeline control
  logic [9:1] vld;
  logic [9:1] en;

  always_comb begin
    en[9] = !vld[9] || upd_ready;
    for (int k = 8; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign req_ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (en & {vld[8:1], req_valid}) | (~en & vld);
    end
  end

  // stage 1: life, rate and friction products, heading upper bits divided by 45
  logic signed [32:0] life_wide;
  logic [28:0]        m45_prod;
  logic signed [31:0] s1_life_next;
  logic signed [49:0] s1_rate_dt_next;
  logic signed [49:0] s1_fric_dt_next;
  logic [13:0]        s1_v_next;
  logic [7:0]         s1_q45_next;

  pmu_req_t           s1_req;
  logic signed [31:0] s1_life;
  logic signed [49:0] s1_rate_dt;
  logic signed [49:0] s1_fric_dt;
  logic [13:0]        s1_v;
  logic [7:0]         s1_q45;

  always_comb begin
    life_wide = $signed({req_data.life_left[31], req_data.life_left})
              - $signed({16'd0, time_step});
    s1_life_next    = sat_q32(64'(life_wide));
    s1_rate_dt_next = 50'(req_data.spin_rate) * 50'(dt_s);
    s1_fric_dt_next = 50'(req_data.friction_rate) * 50'(dt_s);
    s1_v_next       = {req_data.heading[31], req_data.heading[31:19]} + HEAD_OFS;
    m45_prod        = 29'(s1_v_next) * 29'(MOD45_RCP);
    s1_q45_next     = m45_prod[MOD45_SHIFT +: 8];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_req     <= req_data;
      s1_life    <= s1_life_next;
      s1_rate_dt <= s1_rate_dt_next;
      s1_fric_dt <= s1_fric_dt_next;
      s1_v       <= s1_v_next;
      s1_q45     <= s1_q45_next;
    end
  end

  // stage 2: speed, angle, interpolation products, heading remainder
  logic signed [34:0] spd_w;
  logic signed [34:0] ang_w;
  logic [30:0]        ns;
  logic signed [32:0] scale_diff;
  logic [5:0]         m45;
  pmu_upd_t           s2_res_next;
  logic signed [64:0] s2_sprod_next;
  logic signed [40:0] s2_cprod_next [4];
  logic [24:0]        s2_b_next;

  pmu_upd_t           s2_res;
  logic signed [64:0] s2_sprod;
  logic signed [40:0] s2_cprod [4];
  logic [24:0]        s2_b;

  always_comb begin
    spd_w = 35'(s1_req.speed_now) - 35'($signed(s1_fric_dt[49:16]));
    priority if (spd_w < 0) begin
      ns = '0;
    end else if (spd_w > 35'sd2147483647) begin
      ns = 31'h7FFF_FFFF;
    end else begin
      ns = spd_w[30:0];
    end
    ang_w = 35'(s1_req.spin_angle) + 35'($signed(s1_rate_dt[49:16]));

    s2_res_next.alive     = !s1_life[31];
    s2_res_next.life_out  = s1_life;
    s2_res_next.scale_out = s1_req.scale_now;
    s2_res_next.color_out = s1_req.color_now;
    s2_res_next.x_out     = s1_req.pos_x;
    s2_res_next.y_out     = s1_req.pos_y;
    if (s1_life[31]) begin
      s2_res_next.angle_out = s1_req.spin_angle;
      s2_res_next.speed_out = s1_req.speed_now[31] ? '0 : s1_req.speed_now[30:0];
    end else begin
      s2_res_next.angle_out = sat_q32(64'(ang_w));
      s2_res_next.speed_out = ns;
    end

    scale_diff    = 33'(s1_req.scale_target) - 33'(s1_req.scale_now);
    s2_sprod_next = 65'(scale_diff) * 65'(s1_life);
    for (int c = 0; c < 4; c++) begin
      s2_cprod_next[c] = 41'($signed({1'b0, s1_req.color_target[8*c +: 8]})
                           - $signed({1'b0, s1_req.color_now[8*c +: 8]})) * 41'(s1_life);
    end

    m45       = 6'(s1_v - 14'(s1_q45) * 14'd45);
    s2_b_next = {m45, s1_req.heading[18:0]};
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_res   <= s2_res_next;
      s2_sprod <= s2_sprod_next;
      s2_cprod <= s2_cprod_next;
      s2_b     <= s2_b_next;
    end
  end

  // stage 3: scale and color sums, heading remainder times depth
  logic signed [49:0]  scale_w;
  pmu_upd_t            s3_res_next;
  logic [PROD_W-1:0]   s3_p_next;

  pmu_upd_t            s3_res;
  logic [PROD_W-1:0]   s3_p;

  always_comb begin
    s3_res_next = s2_res;
    scale_w     = 50'(s2_res.scale_out) + 50'($signed(s2_sprod[64:16]));
    if (s2_res.alive) begin
      s3_res_next.scale_out = sat_q32(64'(scale_w));
      for (int c = 0; c < 4; c++) begin
        s3_res_next.color_out[8*c +: 8] =
          clamp_u8(26'($signed({1'b0, s2_res.color_out[8*c +: 8]}))
                 + 26'($signed(s2_cprod[c][40:16])));
      end
    end
    s3_p_next = PROD_W'(s2_b) * PROD_W'(DEPTH_V);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_res <= s3_res_next;
      s3_p   <= s3_p_next;
    end
  end

  // stage 4: table index, divide by 45 via reciprocal
  logic [W_W-1:0]     w;
  logic [IPROD_W-1:0] iprod;
  pmu_upd_t           s4_res;
  logic [IDX_W-1:0]   s4_idx;

  always_comb begin
    w     = s3_p[19 +: W_W];
    iprod = IPROD_W'(w) * IPROD_W'(RCP);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_res <= s3_res;
      s4_idx <= iprod[RCP_SHIFT +: IDX_W];
    end
  end

  // stage 5: quarter-wave fold for sine and cosine
  logic [FOLD_W-1:0]  m_s;
  logic [FOLD_W-1:0]  m_c;
  logic [DEPTH_W:0]   f_s;
  logic [DEPTH_W:0]   f_c;
  pmu_upd_t           s5_res;
  logic [DEPTH_W-1:0] s5_r_s;
  logic [DEPTH_W-1:0] s5_r_c;
  logic               s5_neg_s;
  logic               s5_neg_c;

  always_comb begin
    m_s = FOLD_W'({s4_idx, 2'b00});
    m_c = m_s + Q1;
    if (m_c >= Q4) begin
      m_c = m_c - Q4;
    end
    f_s = fold(m_s);
    f_c = fold(m_c);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_res   <= s4_res;
      s5_r_s   <= f_s[DEPTH_W-1:0];
      s5_neg_s <= f_s[DEPTH_W];
      s5_r_c   <= f_c[DEPTH_W-1:0];
      s5_neg_c <= f_c[DEPTH_W];
    end
  end

  // stage 6: sine table read
  pmu_upd_t         s6_res;
  logic [SIN_W-1:0] s6_mag_s;
  logic [SIN_W-1:0] s6_mag_c;
  logic             s6_neg_s;
  logic             s6_neg_c;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_res   <= s5_res;
      s6_mag_s <= SINE_ROM[s5_r_s];
      s6_mag_c <= SINE_ROM[s5_r_c];
      s6_neg_s <= s5_neg_s;
      s6_neg_c <= s5_neg_c;
    end
  end

  // stage 7: velocity = speed * trig
  logic signed [17:0] sn;
  logic signed [17:0] cs;
  logic signed [31:0] spd_s;
  pmu_upd_t           s7_res;
  logic signed [49:0] s7_vx;
  logic signed [49:0] s7_vy;

  always_comb begin
    sn    = s6_neg_s ? -$signed({1'b0, s6_mag_s}) : $signed({1'b0, s6_mag_s});
    cs    = s6_neg_c ? -$signed({1'b0, s6_mag_c}) : $signed({1'b0, s6_mag_c});
    spd_s = $signed({1'b0, s6_res.speed_out});
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_res <= s6_res;
      s7_vx  <= 50'(spd_s) * 50'(cs);
      s7_vy  <= 50'(spd_s) * 50'(sn);
    end
  end

  // stage 8: step = velocity * time step
  pmu_upd_t           s8_res;
  logic signed [51:0] s8_stx;
  logic signed [51:0] s8_sty;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_res <= s7_res;
      s8_stx <= 52'($signed(s7_vx[49:16])) * 52'(dt_s);
      s8_sty <= 52'($signed(s7_vy[49:16])) * 52'(dt_s);
    end
  end

  // stage 9: position sums, output register
  logic signed [36:0] x_w;
  logic signed [36:0] y_w;
  pmu_upd_t           s9_res_next;
  pmu_upd_t           s9_res;

  always_comb begin
    s9_res_next = s8_res;
    x_w = 37'(s8_res.x_out) + 37'($signed(s8_stx[51:16]));
    y_w = 37'(s8_res.y_out) + 37'($signed(s8_sty[51:16]));
    if (s8_res.alive) begin
      s9_res_next.x_out = sat_q32(64'(x_w));
      s9_res_next.y_out = sat_q32(64'(y_w));
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_res <= s9_res_next;
    end
  end

  assign upd_valid = vld[9];
  assign upd_data  = s9_res;

  `PMU_ASSERT_IMP(a_alive_life, upd_valid, upd_data.alive == !upd_data.life_out[31], "alive flag disagrees with life sign")
  `PMU_ASSERT_IMP(a_full_stall, !req_ready, &vld, "request held off with a free stage")
  `PMU_ASSERT_IMP(a_fold_range, vld[5], (s5_r_s <= DEPTH_V) && (s5_r_c <= DEPTH_V), "folded table offset out of range")
  `PMU_ASSERT_NXT(a_load, req_valid && req_ready, vld[1], "accepted request missing from first stage")

endmodule
